### design/segment_slab_clipper_macros.svh
// Assertion macros used by the segment slab clipper queue (sscl_fifo).
`ifndef SEGMENT_SLAB_CLIPPER_MACROS_SVH
`define SEGMENT_SLAB_CLIPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSCL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sscl assertion failed");

// Next-cycle implication, disabled during reset.
`define SSCL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sscl assertion failed");

`endif

### design/sscl_pkg.sv
// Types and constants shared by the segment slab clipper modules.
`default_nettype none
package sscl_pkg;
   localparam int COORD_W    = 32;
   localparam int NORM_W     = 16;
   localparam int OPROJ_W    = 32;
   localparam int SPACE_W    = 21;
   localparam int IDX_W      = 12;
   localparam int OFF_W      = 35;
   localparam int PROD_W     = 48;
   localparam int DOT_W      = 50;
   localparam int DOT_SHIFT  = 14;
   localparam int DOT16_W    = DOT_W - DOT_SHIFT;
   localparam int DIST_W     = 40;
   localparam int DELTA_W    = 41;
   localparam int NUM_W      = 43;
   localparam int MAG_W      = 43;
   localparam int REM_W      = 45;
   localparam int TFRAC      = 28;
   localparam int Q_W        = TFRAC + 1;
   localparam int T_W        = 31;
   localparam int DIFF_W     = 33;
   localparam int LERP_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Q_DEPTH    = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X     = 3'd0,
      CSR_NORMAL_Y     = 3'd1,
      CSR_NORMAL_Z     = 3'd2,
      CSR_ORIGIN_PROJ  = 3'd3,
      CSR_SLICE_SPACE  = 3'd4,
      CSR_SLICE_INDEX  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
   } seg_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic signed [OFF_W-1:0]  offset;
      logic [SPACE_W-1:0]       h;
   } cfg_type;

   typedef struct packed {
      seg_type          seg;
      logic             par;
      logic             par_ok;
      logic [MAG_W-1:0] den;
      logic             lo_neg;
      logic [MAG_W-1:0] lo_mag;
      logic             hi_neg;
      logic [MAG_W-1:0] hi_mag;
   } item_type;

   typedef struct packed {
      seg_type seg;
      logic    par;
      logic    par_ok;
   } side_type;
endpackage
`default_nettype wire

### design/sscl_fifo.sv
// Short item queue between the classify front and the clip back.
`default_nettype none
module sscl_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sscl_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sscl_pkg::item_type pop_item
);
   import sscl_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   item_type           mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`include "segment_slab_clipper_macros.svh"
   `SSCL_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(Q_DEPTH))
   `SSCL_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))
   `SSCL_ASSERT_NXT(a_count_dn, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1))
   `SSCL_ASSERT_IMP(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)
endmodule
`default_nettype wire

### design/sscl_div.sv
// Pipelined restoring divider producing a signed Q2.28 clip parameter.
`default_nettype none
module sscl_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic                           neg,
   input  logic [sscl_pkg::MAG_W-1:0]     mag,
   input  logic [sscl_pkg::MAG_W-1:0]     den,
   output logic signed [sscl_pkg::T_W-1:0] quot
);
   import sscl_pkg::*;

   localparam int STAGES = Q_W;

   logic [REM_W-1:0] rem_ff [1:STAGES];
   logic [Q_W-1:0]   quo_ff [1:STAGES];
   logic [REM_W-1:0] den_ff [1:STAGES];
   logic             sat_ff [1:STAGES];
   logic             neg_ff [1:STAGES];

   logic [REM_W-1:0] mag_w, den_w, rem0_in;
   logic             bit0, sat0;
   logic [REM_W-1:0] shl [2:STAGES];
   logic             qbit [2:STAGES];
   logic [Q_W:0]     qmag;

   always_comb begin
      mag_w   = REM_W'(mag);
      den_w   = REM_W'(den);
      sat0    = mag_w >= (den_w << 1);
      bit0    = mag_w >= den_w;
      rem0_in = bit0 ? mag_w - den_w : mag_w;
      for (int s = 2; s <= STAGES; s++) begin
         shl[s]  = rem_ff[s-1] << 1;
         qbit[s] = shl[s] >= den_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[1] <= rem0_in;
         quo_ff[1] <= Q_W'(bit0);
         den_ff[1] <= den_w;
         sat_ff[1] <= sat0;
         neg_ff[1] <= neg;
         for (int s = 2; s <= STAGES; s++) begin
            rem_ff[s] <= qbit[s] ? shl[s] - den_ff[s-1] : shl[s];
            quo_ff[s] <= {quo_ff[s-1][Q_W-2:0], qbit[s]};
            den_ff[s] <= den_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   // Saturate at two when the numerator reaches twice the denominator.
   assign qmag = sat_ff[STAGES] ? {1'b1, {Q_W{1'b0}}} : {1'b0, quo_ff[STAGES]};
   assign quot = neg_ff[STAGES] ? -$signed(T_W'(qmag)) : $signed(T_W'(qmag));
endmodule
`default_nettype wire

### design/sscl_front.sv
// Front pipeline: plane distances and slab classification of each segment.
`default_nettype none
module sscl_front (
   input  logic               clock,
   input  logic               reset,
   input  sscl_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  sscl_pkg::seg_type  in_seg,
   output logic               out_valid,
   input  logic               out_ready,
   output sscl_pkg::item_type out_item
);
   import sscl_pkg::*;

   localparam logic signed [DOT_W-1:0]   DOT_RND = DOT_W'(8192);
   localparam logic signed [DELTA_W-1:0] D_ONE   = DELTA_W'(1);

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   seg_type seg1_ff, seg2_ff, seg3_ff, seg4_ff, seg5_ff, seg6_ff;

   logic signed [PROD_W-1:0]  pa_ff [3];
   logic signed [PROD_W-1:0]  pb_ff [3];
   logic signed [DOT_W-1:0]   dot_a, dot_b;
   logic signed [DOT16_W-1:0] d16a_ff, d16b_ff;
   logic signed [DIST_W-1:0]  da_ff, db_ff;
   logic signed [DELTA_W-1:0] delta_ff, da2_ff;
   logic [DELTA_W-1:0]        abs_da2, abs_delta;
   logic                      pos;
   logic                      par5_ff, pok5_ff, par6_ff, pok6_ff;
   logic [MAG_W-1:0]          den5_ff, den6_ff;
   logic signed [NUM_W-1:0]   e_ff, nlo_ff, nhi_ff, e_in, h_n;
   item_type                  item_ff;

   // Advance unless the last stage holds an item the queue cannot take.
   assign en        = !(v7_ff && !out_ready);
   assign in_ready  = en;
   assign out_valid = v7_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff} <= '0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_comb begin
      dot_a = DOT_W'(pa_ff[0]) + DOT_W'(pa_ff[1]) + DOT_W'(pa_ff[2]) + DOT_RND;
      dot_b = DOT_W'(pb_ff[0]) + DOT_W'(pb_ff[1]) + DOT_W'(pb_ff[2]) + DOT_RND;
      abs_da2   = da2_ff[DELTA_W-1] ? DELTA_W'(-da2_ff) : DELTA_W'(da2_ff);
      abs_delta = delta_ff[DELTA_W-1] ? DELTA_W'(-delta_ff) : DELTA_W'(delta_ff);
      pos       = delta_ff > 0;
      e_in      = pos ? -NUM_W'(da2_ff) : NUM_W'(da2_ff);
      h_n       = NUM_W'($signed({1'b0, cfg.h}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg1_ff  <= in_seg;
         pa_ff[0] <= in_seg.a_x * cfg.nx;
         pa_ff[1] <= in_seg.a_y * cfg.ny;
         pa_ff[2] <= in_seg.a_z * cfg.nz;
         pb_ff[0] <= in_seg.b_x * cfg.nx;
         pb_ff[1] <= in_seg.b_y * cfg.ny;
         pb_ff[2] <= in_seg.b_z * cfg.nz;

         // round the Q.30 dot product to Q.16
         seg2_ff <= seg1_ff;
         d16a_ff <= dot_a[DOT_W-1:DOT_SHIFT];
         d16b_ff <= dot_b[DOT_W-1:DOT_SHIFT];

         seg3_ff <= seg2_ff;
         da_ff   <= DIST_W'(d16a_ff) - DIST_W'(cfg.offset);
         db_ff   <= DIST_W'(d16b_ff) - DIST_W'(cfg.offset);

         seg4_ff  <= seg3_ff;
         delta_ff <= DELTA_W'(db_ff) - DELTA_W'(da_ff);
         da2_ff   <= DELTA_W'(da_ff) <<< 1;

         seg5_ff <= seg4_ff;
         par5_ff <= (delta_ff >= -D_ONE) && (delta_ff <= D_ONE);
         pok5_ff <= (DELTA_W'(abs_da2) <= DELTA_W'(cfg.h) + DELTA_W'(2));
         den5_ff <= MAG_W'(abs_delta) << 1;
         e_ff    <= e_in;

         seg6_ff <= seg5_ff;
         par6_ff <= par5_ff;
         pok6_ff <= pok5_ff;
         den6_ff <= den5_ff;
         nlo_ff  <= e_ff - h_n;
         nhi_ff  <= e_ff + h_n;

         item_ff.seg    <= seg6_ff;
         item_ff.par    <= par6_ff;
         item_ff.par_ok <= pok6_ff;
         item_ff.den    <= den6_ff;
         item_ff.lo_neg <= nlo_ff[NUM_W-1];
         item_ff.lo_mag <= nlo_ff[NUM_W-1] ? MAG_W'(-nlo_ff) : MAG_W'(nlo_ff);
         item_ff.hi_neg <= nhi_ff[NUM_W-1];
         item_ff.hi_mag <= nhi_ff[NUM_W-1] ? MAG_W'(-nhi_ff) : MAG_W'(nhi_ff);
      end
   end
endmodule
`default_nettype wire

### design/sscl_back.sv
// Back pipeline: clip parameters by division, then endpoint interpolation.
`default_nettype none
module sscl_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  sscl_pkg::item_type                in_item,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_accepted,
   output logic signed [sscl_pkg::COORD_W-1:0] out_a_x,
   output logic signed [sscl_pkg::COORD_W-1:0] out_a_y,
   output logic signed [sscl_pkg::COORD_W-1:0] out_a_z,
   output logic signed [sscl_pkg::COORD_W-1:0] out_b_x,
   output logic signed [sscl_pkg::COORD_W-1:0] out_b_y,
   output logic signed [sscl_pkg::COORD_W-1:0] out_b_z
);
   import sscl_pkg::*;

   localparam int STAGES = Q_W;
   localparam logic signed [T_W-1:0]    T_ONE = T_W'(1 << TFRAC);
   localparam logic signed [LERP_W-1:0] L_RND = LERP_W'(1 << (TFRAC - 1));

   logic en;
   logic vld_ff [1:STAGES];
   side_type side_ff [1:STAGES];
   side_type side_in;
   logic vc_ff, vm_ff, vo_ff;

   logic signed [T_W-1:0] tlo, thi, beg_in, end_in;
   logic ok_in;

   logic signed [COORD_W-1:0] ac_ff [3];
   logic signed [DIFF_W-1:0]  diff_ff [3];
   logic signed [T_W-1:0]     beg_ff, end_ff;
   logic                      okc_ff;

   logic signed [COORD_W-1:0] am_ff [3];
   logic signed [LERP_W-1:0]  pbeg_ff [3];
   logic signed [LERP_W-1:0]  pend_ff [3];
   logic                      okm_ff;

   logic signed [LERP_W-1:0]  sbeg [3];
   logic signed [LERP_W-1:0]  send [3];
   logic signed [COORD_W-1:0] cb_in [3];
   logic signed [COORD_W-1:0] ce_in [3];
   logic signed [COORD_W-1:0] ob_ff [3];
   logic signed [COORD_W-1:0] oe_ff [3];
   logic                      oacc_ff;

   // Advance whenever the output register is free or being drained.
   assign en        = !vo_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = vo_ff;

   assign side_in.seg    = in_item.seg;
   assign side_in.par    = in_item.par;
   assign side_in.par_ok = in_item.par_ok;

   sscl_div u_div_lo (
      .clock (clock),
      .en    (en),
      .neg   (in_item.lo_neg),
      .mag   (in_item.lo_mag),
      .den   (in_item.den),
      .quot  (tlo)
   );

   sscl_div u_div_hi (
      .clock (clock),
      .en    (en),
      .neg   (in_item.hi_neg),
      .mag   (in_item.hi_mag),
      .den   (in_item.den),
      .quot  (thi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
         vc_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= in_valid;
         for (int s = 2; s <= STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         vc_ff <= vld_ff[STAGES];
         vm_ff <= vc_ff;
         vo_ff <= vm_ff;
      end
   end

   always_comb begin
      if (side_ff[STAGES].par) begin
         beg_in = '0;
         end_in = T_ONE;
         ok_in  = side_ff[STAGES].par_ok;
      end else begin
         beg_in = (tlo > 0) ? tlo : '0;
         end_in = (thi < T_ONE) ? thi : T_ONE;
         ok_in  = !((T_W+1)'(beg_in) > (T_W+1)'(end_in) + (T_W+1)'(1));
      end
      for (int i = 0; i < 3; i++) begin
         sbeg[i]  = (pbeg_ff[i] + L_RND) >>> TFRAC;
         send[i]  = (pend_ff[i] + L_RND) >>> TFRAC;
         cb_in[i] = am_ff[i] + sbeg[i][COORD_W-1:0];
         ce_in[i] = am_ff[i] + send[i][COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= side_in;
         for (int s = 2; s <= STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end

         beg_ff     <= beg_in;
         end_ff     <= end_in;
         okc_ff     <= ok_in;
         ac_ff[0]   <= side_ff[STAGES].seg.a_x;
         ac_ff[1]   <= side_ff[STAGES].seg.a_y;
         ac_ff[2]   <= side_ff[STAGES].seg.a_z;
         diff_ff[0] <= DIFF_W'(side_ff[STAGES].seg.b_x) - DIFF_W'(side_ff[STAGES].seg.a_x);
         diff_ff[1] <= DIFF_W'(side_ff[STAGES].seg.b_y) - DIFF_W'(side_ff[STAGES].seg.a_y);
         diff_ff[2] <= DIFF_W'(side_ff[STAGES].seg.b_z) - DIFF_W'(side_ff[STAGES].seg.a_z);

         okm_ff <= okc_ff;
         for (int i = 0; i < 3; i++) begin
            am_ff[i]   <= ac_ff[i];
            pbeg_ff[i] <= diff_ff[i] * beg_ff;
            pend_ff[i] <= diff_ff[i] * end_ff;
         end

         // rejected segments report all-zero endpoints
         oacc_ff <= okm_ff;
         for (int i = 0; i < 3; i++) begin
            ob_ff[i] <= okm_ff ? cb_in[i] : '0;
            oe_ff[i] <= okm_ff ? ce_in[i] : '0;
         end
      end
   end

   assign out_accepted = oacc_ff;
   assign out_a_x      = ob_ff[0];
   assign out_a_y      = ob_ff[1];
   assign out_a_z      = ob_ff[2];
   assign out_b_x      = oe_ff[0];
   assign out_b_y      = oe_ff[1];
   assign out_b_z      = oe_ff[2];
endmodule
`default_nettype wire

### design/segment_slab_clipper.sv
// Top level of the segment slab clipper: config registers, front, queue, back.
//
//   channel  prefix  direction  handshake     contents
//   request  req_    in         valid/ready   segment endpoints a, b
//   result   rsp_    out        valid/ready   accept flag, clipped endpoints
//   config   csr_    in         write enable  register index and data
//
// One segment per cycle sustained while rsp_ready is held; the front, the queue
// and the back are registered, and the back holds the 29-stage clip divider.
// Reset clears all item valids and loads the register defaults.
// A stalled result stops the back pipeline; the 4-entry queue then fills
// before the front and req_ready stall.
`default_nettype none
module segment_slab_clipper #(
   parameter int MAX_SLICES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_a_x,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_a_y,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_a_z,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_b_x,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_b_y,
   input  logic signed [sscl_pkg::COORD_W-1:0] req_b_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_a_x,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_a_y,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_a_z,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_b_x,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_b_y,
   output logic signed [sscl_pkg::COORD_W-1:0] rsp_clip_b_z,
   input  logic                                csr_we,
   input  logic [sscl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sscl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sscl_pkg::*;

   localparam logic [16:0] IDX_MAX = 17'(MAX_SLICES - 1);

   logic signed [NORM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic signed [OPROJ_W-1:0] oproj_ff;
   logic [SPACE_W-1:0]        space_ff;
   logic [IDX_W-1:0]          sidx_ff, sidx_eff;
   logic signed [OFF_W-1:0]   offset_ff;
   cfg_type                   cfg;
   seg_type                   req_seg;
   item_type                  f_item, q_item;
   logic                      f_valid, f_ready, q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff    <= '0;
         ny_ff    <= '0;
         nz_ff    <= NORM_W'(16384);
         oproj_ff <= '0;
         space_ff <= SPACE_W'(65536);
         sidx_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NORMAL_X:    nx_ff    <= csr_wdata[NORM_W-1:0];
            CSR_NORMAL_Y:    ny_ff    <= csr_wdata[NORM_W-1:0];
            CSR_NORMAL_Z:    nz_ff    <= csr_wdata[NORM_W-1:0];
            CSR_ORIGIN_PROJ: oproj_ff <= csr_wdata[OPROJ_W-1:0];
            CSR_SLICE_SPACE: space_ff <= csr_wdata[SPACE_W-1:0];
            CSR_SLICE_INDEX: sidx_ff  <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   assign sidx_eff = (17'(sidx_ff) > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : sidx_ff;

   // hold origin projection plus plane position, refreshed every cycle
   always_ff @(posedge clock) begin
      offset_ff <= OFF_W'(oproj_ff)
                 + $signed({2'b00, 33'(sidx_eff) * 33'(space_ff)});
   end

   assign cfg.nx     = nx_ff;
   assign cfg.ny     = ny_ff;
   assign cfg.nz     = nz_ff;
   assign cfg.offset = offset_ff;
   assign cfg.h      = space_ff;

   assign req_seg.a_x = req_a_x;
   assign req_seg.a_y = req_a_y;
   assign req_seg.a_z = req_a_z;
   assign req_seg.b_x = req_b_x;
   assign req_seg.b_y = req_b_y;
   assign req_seg.b_z = req_b_z;

   sscl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_seg    (req_seg),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   sscl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   sscl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_item      (q_item),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_accepted (rsp_accepted),
      .out_a_x      (rsp_clip_a_x),
      .out_a_y      (rsp_clip_a_y),
      .out_a_z      (rsp_clip_a_z),
      .out_b_x      (rsp_clip_b_x),
      .out_b_y      (rsp_clip_b_y),
      .out_b_z      (rsp_clip_b_z)
   );
endmodule
`default_nettype wire
